// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared codes, field widths and parameter defaults for the block buffer
// cache tag manager.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int SLOTS_DEFAULT   = 32;
   localparam int REF_MAX_DEFAULT = 255;

   localparam int OP_W      = 2;
   localparam int DEV_W     = 8;
   localparam int BLK_W     = 32;
   localparam int SLOT_W    = 5;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 64;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 144;

   // operation codes (req_tuser)
   localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_DIRTY   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_HELD = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

endpackage

// ===== rtl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/block_buffer_cache_lru_top.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_top
// Tag manager for a block buffer cache: acquire by tag with refcounts,
// release, mark dirty, least-recently-used victim choice.
// Acquire, and a release that frees the entry, walk every entry with one RAM
//   read each; other release and dirty requests read only their slot, and an
//   unused code answers without a read. A stalled response word holds the next
//   answer back. One request in flight.
// Reset clears control, counters and the per-entry written flags; an entry
//   never written reads as its reset value, no clearing pass.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_top #(
   parameter int SLOTS   = bbc_pkg::SLOTS_DEFAULT,
   parameter int REF_MAX = bbc_pkg::REF_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // device[7:0], block_number[39:8], slot[44:40], zero pad
   input  logic [bbc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[1:0]
   input  logic [bbc_pkg::OP_W-1:0]        req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot_out[4:0], hit[5], fetch_needed[6], status[8:7],
   // hits_total[72:9], misses_total[136:73], zero pad
   output logic [bbc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int IDXW = $clog2(SLOTS);
   localparam int CNTW = IDXW + 1;
   localparam int REFW = $clog2(REF_MAX + 1);
   localparam int PADW = bbc_pkg::RSP_DATA_W - (bbc_pkg::SLOT_W + 2 + bbc_pkg::STATUS_W
                         + 2 * bbc_pkg::COUNT_W);

   typedef struct packed {
      logic [bbc_pkg::DEV_W-1:0] tag_dev;
      logic [bbc_pkg::BLK_W-1:0] tag_blk;
      logic                      valid;
      logic                      dirty;
      logic [REFW-1:0]           refs;
      logic [IDXW-1:0]           rank;
   } entry_type;

   localparam int EW = $bits(entry_type);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SLOT   = 3'd3;
   localparam logic [2:0] ST_SWEEP  = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // control
   logic [2:0]                     state_ff, state_in;
   logic [CNTW-1:0]                cnt_ff, cnt_in;
   logic                           rd_live_ff, rd_live_in;
   logic [SLOTS-1:0]               written_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bbc_pkg::COUNT_W-1:0]    hit_cnt_ff, hit_cnt_in;
   logic [bbc_pkg::COUNT_W-1:0]    miss_cnt_ff, miss_cnt_in;
   logic                           m_found_ff, m_found_in;
   logic                           f_found_ff, f_found_in;

   // payload
   logic [bbc_pkg::OP_W-1:0]       op_ff, op_in;
   logic [bbc_pkg::DEV_W-1:0]      dev_ff, dev_in;
   logic [bbc_pkg::BLK_W-1:0]      blk_ff, blk_in;
   logic [IDXW-1:0]                slot_idx_ff, slot_idx_in;
   logic [IDXW-1:0]                rd_idx_ff;
   logic                           seen_ff;
   logic [IDXW-1:0]                m_idx_ff, m_idx_in;
   entry_type                      m_word_ff, m_word_in;
   logic [IDXW-1:0]                f_idx_ff, f_idx_in;
   logic [IDXW-1:0]                f_rank_ff, f_rank_in;
   logic [IDXW-1:0]                rel_rank_ff, rel_rank_in;
   logic [bbc_pkg::SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                           res_hit_ff, res_hit_in;
   logic                           res_fetch_ff, res_fetch_in;
   logic [bbc_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [bbc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic            rd_issue;
   logic [IDXW-1:0] rd_addr;
   logic            wr_en;
   logic [IDXW-1:0] wr_addr;
   entry_type       wr_data;
   logic [EW-1:0]   ram_q;

   // decoded request
   logic [bbc_pkg::DEV_W-1:0]  req_dev;
   logic [bbc_pkg::BLK_W-1:0]  req_blk;
   logic [bbc_pkg::SLOT_W-1:0] req_slot;
   logic                       req_slot_ok;

   entry_type cur;
   logic      cur_match;
   logic      cur_free;

   assign req_dev     = req_tdata[7:0];
   assign req_blk     = req_tdata[39:8];
   assign req_slot    = req_tdata[44:40];
   assign req_slot_ok = 32'(req_slot) < 32'(SLOTS);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bbc_ram #(
      .WIDTH (EW),
      .DEPTH (SLOTS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // entry never written reads as its reset value: tags zero, rank SLOTS-1-i
   always_comb begin
      if (seen_ff) begin
         cur = entry_type'(ram_q);
      end else begin
         cur      = '0;
         cur.rank = IDXW'(SLOTS - 1) - rd_idx_ff;
      end
   end

   assign cur_match = (cur.tag_dev == dev_ff) && (cur.tag_blk == blk_ff);
   assign cur_free  = (cur.refs == '0);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      m_found_in    = m_found_ff;
      f_found_in    = f_found_ff;
      op_in         = op_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      slot_idx_in   = slot_idx_ff;
      m_idx_in      = m_idx_ff;
      m_word_in     = m_word_ff;
      f_idx_in      = f_idx_ff;
      f_rank_in     = f_rank_ff;
      rel_rank_in   = rel_rank_ff;
      res_slot_in   = res_slot_ff;
      res_hit_in    = res_hit_ff;
      res_fetch_in  = res_fetch_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rd_issue      = 1'b0;
      rd_addr       = cnt_ff[IDXW-1:0];
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = cur;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               dev_in        = req_dev;
               blk_in        = req_blk;
               slot_idx_in   = IDXW'(req_slot);
               res_slot_in   = req_slot;
               res_hit_in    = 1'b0;
               res_fetch_in  = 1'b0;
               res_status_in = bbc_pkg::STAT_OK;
               case (req_tuser)
                  bbc_pkg::OP_ACQUIRE: begin
                     m_found_in  = 1'b0;
                     f_found_in  = 1'b0;
                     cnt_in      = '0;
                     res_slot_in = '0;
                     state_in    = ST_SCAN;
                  end
                  bbc_pkg::OP_RELEASE, bbc_pkg::OP_DIRTY: begin
                     if (!req_slot_ok) begin
                        res_status_in = bbc_pkg::STAT_NOT_HELD;
                        state_in      = ST_DONE;
                     end else begin
                        rd_addr  = IDXW'(req_slot);
                        rd_issue = 1'b1;
                        state_in = ST_SLOT;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (cnt_ff < CNTW'(SLOTS)) begin
               rd_issue = 1'b1;
               cnt_in   = cnt_ff + CNTW'(1);
            end
            if (rd_live_ff) begin
               // most recent match: lowest rank; victim: least recent free
               if (cur_match && (!m_found_ff || cur.rank < m_word_ff.rank)) begin
                  m_found_in = 1'b1;
                  m_idx_in   = rd_idx_ff;
                  m_word_in  = cur;
               end
               if (cur_free && (!f_found_ff || cur.rank > f_rank_ff)) begin
                  f_found_in = 1'b1;
                  f_idx_in   = rd_idx_ff;
                  f_rank_in  = cur.rank;
               end
            end
            if (cnt_ff == CNTW'(SLOTS)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            state_in = ST_DONE;
            if (m_found_ff) begin
               res_slot_in = bbc_pkg::SLOT_W'(m_idx_ff);
               if (m_word_ff.refs >= REFW'(REF_MAX)) begin
                  res_status_in = bbc_pkg::STAT_OVERFLOW;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = m_idx_ff;
                  wr_data       = m_word_ff;
                  wr_data.refs  = m_word_ff.refs + REFW'(1);
                  wr_data.valid = 1'b1;
                  if (m_word_ff.valid) begin
                     res_hit_in = 1'b1;
                     hit_cnt_in = hit_cnt_ff + 64'd1;
                  end else begin
                     res_fetch_in = 1'b1;
                     miss_cnt_in  = miss_cnt_ff + 64'd1;
                  end
               end
            end else if (f_found_ff) begin
               res_slot_in     = bbc_pkg::SLOT_W'(f_idx_ff);
               wr_en           = 1'b1;
               wr_addr         = f_idx_ff;
               wr_data.tag_dev = dev_ff;
               wr_data.tag_blk = blk_ff;
               wr_data.valid   = 1'b1;
               wr_data.dirty   = 1'b0;
               wr_data.refs    = REFW'(1);
               wr_data.rank    = f_rank_ff;
               res_fetch_in    = 1'b1;
               miss_cnt_in     = miss_cnt_ff + 64'd1;
            end else begin
               res_status_in = bbc_pkg::STAT_NO_FREE;
            end
         end

         ST_SLOT: begin
            state_in = ST_DONE;
            if (cur_free) begin
               res_status_in = bbc_pkg::STAT_NOT_HELD;
            end else if (op_ff == bbc_pkg::OP_DIRTY) begin
               wr_en         = 1'b1;
               wr_data.dirty = 1'b1;
            end else if (cur.refs == REFW'(1)) begin
               // last reference gone: sweep all entries, this one to rank 0, lower ranks up one
               rel_rank_in = cur.rank;
               cnt_in      = '0;
               state_in    = ST_SWEEP;
            end else begin
               wr_en        = 1'b1;
               wr_data.refs = cur.refs - REFW'(1);
            end
         end

         ST_SWEEP: begin
            if (cnt_ff < CNTW'(SLOTS)) begin
               rd_issue = 1'b1;
               cnt_in   = cnt_ff + CNTW'(1);
            end
            if (rd_live_ff) begin
               if (rd_idx_ff == slot_idx_ff) begin
                  wr_en        = 1'b1;
                  wr_data.refs = '0;
                  wr_data.rank = '0;
               end else if (cur.rank < rel_rank_ff) begin
                  wr_en        = 1'b1;
                  wr_data.rank = cur.rank + IDXW'(1);
               end
            end
            if (cnt_ff == CNTW'(SLOTS)) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PADW'(0), miss_cnt_ff, hit_cnt_ff, res_status_ff,
                               res_fetch_ff, res_hit_ff, res_slot_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_live_ff   <= 1'b0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         m_found_ff   <= 1'b0;
         f_found_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_live_ff   <= rd_live_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         m_found_ff   <= m_found_in;
         f_found_ff   <= f_found_in;
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_live_in = rd_issue;

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      slot_idx_ff   <= slot_idx_in;
      rd_idx_ff     <= rd_addr;
      seen_ff       <= written_ff[rd_addr];
      m_idx_ff      <= m_idx_in;
      m_word_ff     <= m_word_in;
      f_idx_ff      <= f_idx_in;
      f_rank_ff     <= f_rank_in;
      rel_rank_ff   <= rel_rank_in;
      res_slot_ff   <= res_slot_in;
      res_hit_ff    <= res_hit_in;
      res_fetch_ff  <= res_fetch_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_hit_xor_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[5] && rsp_tdata[6]))
      else $error("hit and fetch_needed both set");

   a_err_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8:7] != bbc_pkg::STAT_OK) |-> (rsp_tdata[6:5] == 2'b00))
      else $error("error status with hit or fetch set");

   a_counters_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DECIDE) |=> ($stable(hit_cnt_ff) && $stable(miss_cnt_ff)))
      else $error("hit or miss count moved outside the decide step");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_DECIDE || state_ff == ST_SLOT || state_ff == ST_SWEEP))
      else $error("entry write outside an update step");

endmodule
